### hw/rtl/hrt_pkg.sv
// shared types, constants and helpers for the http request header tokenizer
package hrt_pkg;

  localparam int unsigned LimitW = 10;
  localparam int unsigned QueueDepthDefault = 4;
  localparam logic [LimitW-1:0] LineLimitReset = 10'd255;
  localparam logic [LimitW-1:0] LenMax = 10'd1023;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharQmark = 8'h3F;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharComma = 8'h2C;

  localparam int unsigned NumMeth = 4;
  localparam int unsigned MethPosN = 8;

  // method spellings, zero padded past their length
  localparam logic [7:0] MethText [NumMeth][MethPosN] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h00},
    '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] MethLen [NumMeth] = '{3'd3, 3'd4, 3'd7, 3'd5};

  typedef enum logic [2:0] {
    ROLE_NONE    = 3'd0,
    ROLE_METHOD  = 3'd1,
    ROLE_PATH    = 3'd2,
    ROLE_QUERY   = 3'd3,
    ROLE_VERSION = 3'd4,
    ROLE_NAME    = 3'd5,
    ROLE_VALUE   = 3'd6
  } role_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_METHOD   = 2'd1,
    ERR_TOKEN    = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    METH_NONE    = 3'd0,
    METH_GET     = 3'd1,
    METH_POST    = 3'd2,
    METH_OPTIONS = 3'd3,
    METH_TRACE   = 3'd4
  } meth_e;

  typedef enum logic [6:0] {
    PH_METHOD  = 7'b0000001,
    PH_PATH    = 7'b0000010,
    PH_QUERY   = 7'b0000100,
    PH_VERSION = 7'b0001000,
    PH_TAIL    = 7'b0010000,
    PH_NAME    = 7'b0100000,
    PH_VALUE   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic                              is_cr;
    logic                              is_lf;
    logic                              is_sp;
    logic                              is_qm;
    logic                              is_colon;
    logic                              is_comma;
    logic [NumMeth-1:0][MethPosN-1:0]  hit;
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] data;
    byte_cls_t  cls;
  } q_entry_t;

  function automatic byte_cls_t classify_f(input logic [7:0] b);
    byte_cls_t c;
    c.is_cr    = (b == CharCr);
    c.is_lf    = (b == CharLf);
    c.is_sp    = (b == CharSpace);
    c.is_qm    = (b == CharQmark);
    c.is_colon = (b == CharColon);
    c.is_comma = (b == CharComma);
    for (int m = 0; m < NumMeth; m++) begin
      for (int p = 0; p < MethPosN; p++) begin
        c.hit[m][p] = (3'(p) < MethLen[m]) && (b == MethText[m][p]);
      end
    end
    return c;
  endfunction

  function automatic meth_e method_found_f(input logic [NumMeth-1:0] mm,
                                           input logic [2:0] mp);
    meth_e f;
    f = METH_NONE;
    for (int m = 0; m < NumMeth; m++) begin
      if (mm[m] && (mp == MethLen[m])) begin
        f = meth_e'(3'(m + 1));
      end
    end
    return f;
  endfunction

endpackage

### hw/rtl/http_request_header_tokenizer.sv
// top level of the http request header tokenizer
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_byte_i
//  out     | output    | out_valid_o / out_stall_i| out_byte_o, role_o, value_index_o,
//          |           |                          | line_index_o, method_code_o, line_end_o,
//          |           |                          | header_done_o, error_code_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_line_limit_i
//
// one byte per cycle sustained while out_stall_i is low, set by the parsing step in the back stage
// an input transfer reaches the result through the front register, the queue and the output register
// the queue holds QueueDepth bytes so input and output stall independently
// reset is asynchronous and needs no clearing pass; line_limit resets to 255
module http_request_header_tokenizer #(
  parameter int unsigned QueueDepth = hrt_pkg::QueueDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic [2:0]                 role_o,
  output logic [3:0]                 value_index_o,
  output logic [7:0]                 line_index_o,
  output logic [2:0]                 method_code_o,
  output logic                       line_end_o,
  output logic                       header_done_o,
  output logic [1:0]                 error_code_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hrt_pkg::LimitW-1:0] cfg_line_limit_i
);
  import hrt_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  hrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  hrt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  hrt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_line_limit_i (cfg_line_limit_i),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_data_i       (pop_data),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .role_o           (role_o),
    .value_index_o    (value_index_o),
    .line_index_o     (line_index_o),
    .method_code_o    (method_code_o),
    .line_end_o       (line_end_o),
    .header_done_o    (header_done_o),
    .error_code_o     (error_code_o)
  );

  // a blank line is always an lf
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_done_o |-> line_end_o)
    else $error("header_done without line_end");

  // bytes under an error carry no role
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE) |-> (role_o == ROLE_NONE))
    else $error("role given while error held");

  // value index only on header value bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (value_index_o != '0) |-> (role_o == ROLE_VALUE))
    else $error("value index outside header value");

  // a line-ending lf carries no role
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> (role_o == ROLE_NONE) && (out_byte_o == CharLf))
    else $error("bad line end result");

endmodule

### hw/rtl/hrt_front.sv
// front stage: takes request bytes and classifies them for the queue
module hrt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output hrt_pkg::q_entry_t push_data_o
);
  import hrt_pkg::*;

  logic     fv_q, fv_d;
  q_entry_t ent_q;
  logic     accept;

  assign in_stall_o = fv_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    fv_d = fv_q;
    if (accept) begin
      fv_d = 1'b1;
    end else if (push_ready_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q.data <= in_byte_i;
      ent_q.cls  <= classify_f(in_byte_i);
    end
  end

  assign push_valid_o = fv_q;
  assign push_data_o  = ent_q;

endmodule

### hw/rtl/hrt_queue.sv
// short queue between the classifying front and the parsing back
module hrt_queue #(
  parameter int unsigned Depth = hrt_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  hrt_pkg::q_entry_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output hrt_pkg::q_entry_t pop_data_o
);
  import hrt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/hrt_back.sv
// back stage: request parsing state machine and output register
module hrt_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [hrt_pkg::LimitW-1:0]   cfg_line_limit_i,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  hrt_pkg::q_entry_t            pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic [2:0]                   role_o,
  output logic [3:0]                   value_index_o,
  output logic [7:0]                   line_index_o,
  output logic [2:0]                   method_code_o,
  output logic                         line_end_o,
  output logic                         header_done_o,
  output logic [1:0]                   error_code_o
);
  import hrt_pkg::*;

  logic [LimitW-1:0]  limit_q;
  phase_e             phase_q, phase_d;
  logic [LimitW-1:0]  len_q, len_d;
  logic [NumMeth-1:0] mm_q, mm_d;
  logic [2:0]         mp_q, mp_d;
  logic [3:0]         vc_q, vc_d;
  logic [7:0]         lc_q, lc_d;
  logic               ts_q, ts_d;
  err_e               err_q, err_d;
  meth_e              mf_q, mf_d;

  logic               ov_q, ov_d;
  logic [7:0]         ob_q;
  role_e              orole_q, role_c;
  logic [3:0]         ovi_q, vidx_c;
  logic [7:0]         oli_q;
  meth_e              ometh_q;
  logic               olend_q, lend_c;
  logic               ohd_q, hd_c;
  err_e               oerr_q;

  logic               pop;
  byte_cls_t          c;
  meth_e              found;
  logic [NumMeth-1:0] hitv;

  assign pop_ready_o = !ov_q || !out_stall_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign c           = pop_data_i.cls;
  assign found       = method_found_f(mm_q, mp_q);

  always_comb begin
    for (int m = 0; m < NumMeth; m++) begin
      hitv[m] = c.hit[m][mp_q];
    end
  end

  always_comb begin
    logic blank;
    phase_d = phase_q;
    len_d   = len_q;
    mm_d    = mm_q;
    mp_d    = mp_q;
    vc_d    = vc_q;
    lc_d    = lc_q;
    ts_d    = ts_q;
    err_d   = err_q;
    mf_d    = mf_q;
    role_c  = ROLE_NONE;
    vidx_c  = '0;
    lend_c  = 1'b0;
    hd_c    = 1'b0;
    blank   = 1'b0;

    if (c.is_cr) begin
      blank = 1'b0;
    end else if (c.is_lf) begin
      lend_c = 1'b1;
      if (len_q == '0) begin
        hd_c  = 1'b1;
        blank = 1'b1;
      end else begin
        case (phase_q)
          PH_METHOD: begin
            if (ts_q) begin
              mf_d = found;
              if (found == METH_NONE && err_d == ERR_NONE) err_d = ERR_METHOD;
            end
            if (err_d == ERR_NONE) err_d = ERR_TOKEN;
          end
          PH_PATH, PH_QUERY, PH_NAME: begin
            if (err_d == ERR_NONE) err_d = ERR_TOKEN;
          end
          PH_VERSION: begin
            if (!ts_q && err_d == ERR_NONE) err_d = ERR_TOKEN;
          end
          default: begin
          end
        endcase
        if (lc_q != 8'hFF) lc_d = lc_q + 1'b1;
        phase_d = PH_NAME;
        len_d   = '0;
        vc_d    = '0;
        ts_d    = 1'b0;
      end
    end else begin
      if (len_q >= limit_q && err_d == ERR_NONE) err_d = ERR_TOO_LONG;
      if (len_q != LenMax) len_d = len_q + 1'b1;
      case (phase_q)
        PH_METHOD: begin
          if (c.is_sp) begin
            if (ts_q) begin
              mf_d = found;
              if (found == METH_NONE && err_d == ERR_NONE) err_d = ERR_METHOD;
              phase_d = PH_PATH;
              ts_d    = 1'b0;
            end
          end else begin
            role_c = ROLE_METHOD;
            ts_d   = 1'b1;
            mm_d   = mm_q & hitv;
            if (mp_q != 3'd7) mp_d = mp_q + 1'b1;
          end
        end
        PH_PATH: begin
          if (c.is_sp) begin
            if (ts_q) begin
              phase_d = PH_VERSION;
              ts_d    = 1'b0;
            end
          end else if (c.is_qm) begin
            phase_d = PH_QUERY;
            ts_d    = 1'b1;
          end else begin
            role_c = ROLE_PATH;
            ts_d   = 1'b1;
          end
        end
        PH_QUERY: begin
          if (c.is_sp) begin
            phase_d = PH_VERSION;
            ts_d    = 1'b0;
          end else begin
            role_c = ROLE_QUERY;
          end
        end
        PH_VERSION: begin
          if (c.is_sp) begin
            if (ts_q) phase_d = PH_TAIL;
          end else begin
            role_c = ROLE_VERSION;
            ts_d   = 1'b1;
          end
        end
        PH_NAME: begin
          if (c.is_colon) begin
            if (!ts_q && err_d == ERR_NONE) err_d = ERR_TOKEN;
            phase_d = PH_VALUE;
            ts_d    = 1'b0;
            vc_d    = '0;
          end else if (!c.is_sp || ts_q) begin
            role_c = ROLE_NAME;
            ts_d   = 1'b1;
          end
        end
        PH_VALUE: begin
          if (c.is_comma) begin
            if (vc_q != 4'hF) vc_d = vc_q + 1'b1;
            ts_d = 1'b0;
          end else if (!c.is_sp || ts_q) begin
            role_c = ROLE_VALUE;
            ts_d   = 1'b1;
            vidx_c = vc_q;
          end
        end
        default: begin
        end
      endcase
    end

    if (err_d != ERR_NONE) begin
      role_c = ROLE_NONE;
      vidx_c = '0;
    end

    // blank line: report, then back to a fresh request
    if (blank) begin
      phase_d = PH_METHOD;
      len_d   = '0;
      mm_d    = '1;
      mp_d    = '0;
      vc_d    = '0;
      lc_d    = '0;
      ts_d    = 1'b0;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (pop) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LineLimitReset;
      phase_q <= PH_METHOD;
      len_q   <= '0;
      mm_q    <= '1;
      mp_q    <= '0;
      vc_q    <= '0;
      lc_q    <= '0;
      ts_q    <= 1'b0;
      err_q   <= ERR_NONE;
      mf_q    <= METH_NONE;
      ov_q    <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_line_limit_i;
      end
      if (pop) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        mm_q    <= mm_d;
        mp_q    <= mp_d;
        vc_q    <= vc_d;
        lc_q    <= lc_d;
        ts_q    <= ts_d;
        err_q   <= hd_c ? ERR_NONE : err_d;
        mf_q    <= hd_c ? METH_NONE : mf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ob_q    <= pop_data_i.data;
      orole_q <= role_c;
      ovi_q   <= vidx_c;
      oli_q   <= lc_q;
      ometh_q <= mf_d;
      olend_q <= lend_c;
      ohd_q   <= hd_c;
      oerr_q  <= err_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign role_o        = orole_q;
  assign value_index_o = ovi_q;
  assign line_index_o  = oli_q;
  assign method_code_o = ometh_q;
  assign line_end_o    = olend_q;
  assign header_done_o = ohd_q;
  assign error_code_o  = oerr_q;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the http request header tokenizer, directed then random
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrt_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [7:0] out_byte;
    role_e      role;
    logic [3:0] value_index;
    logic [7:0] line_index;
    meth_e      method_code;
    logic       line_end;
    logic       header_done;
    err_e       error_code;
  } tag_t;

  typedef struct {
    int unsigned at;
    tag_t        want;
  } known_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        in_byte_i = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        out_byte_o;
  logic [2:0]        role_o;
  logic [3:0]        value_index_o;
  logic [7:0]        line_index_o;
  logic [2:0]        method_code_o;
  logic              line_end_o;
  logic              header_done_o;
  logic [1:0]        error_code_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_line_limit_i = '0;

  // tokenizer state as seen by the checker
  phase_e            st_phase;
  logic [LimitW-1:0] st_len;
  logic [LimitW-1:0] st_limit;
  logic [3:0]        st_match;
  logic [2:0]        st_pos;
  logic [3:0]        st_vals;
  logic [7:0]        st_lines;
  logic              st_started;
  err_e              st_err;
  meth_e             st_meth;

  string       meth_words [4] = '{"GET", "POST", "OPTIONS", "TRACE"};
  tag_t        pending_tags [$];
  logic [7:0]  stream_q [$];
  tag_t        typed_tag = '0;
  logic        use_typed = 1'b0;
  bit          calm = 1'b0;
  int unsigned fails = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned limit_writes = 0;
  int unsigned requests_ended = 0;
  int unsigned flagged_bytes = 0;
  int unsigned quiet_cycles = 0;

  // blank line, a request with a bare '?' path, a header and a nameless one, then a bad method
  logic [7:0] opening_bytes [28] = '{
    8'h0A, 8'h20, 8'h47, 8'h45, 8'h54, 8'h20, 8'h3F, 8'h3F, 8'h20, 8'h20,
    8'h56, 8'h20, 8'h00, 8'h0D, 8'h0A, 8'h6E, 8'h3A, 8'h20, 8'h61, 8'h2C,
    8'hFF, 8'h0A, 8'h3A, 8'h0A, 8'h0A, 8'h58, 8'h0A, 8'h0A
  };

  known_t known_rows [6] = '{
    '{0,  '{8'h0A, ROLE_NONE, 4'd0, 8'd0, METH_NONE, 1'b1, 1'b1, ERR_NONE}},
    '{22, '{8'h3A, ROLE_NONE, 4'd0, 8'd2, METH_GET,  1'b0, 1'b0, ERR_TOKEN}},
    '{23, '{8'h0A, ROLE_NONE, 4'd0, 8'd2, METH_GET,  1'b1, 1'b0, ERR_TOKEN}},
    '{24, '{8'h0A, ROLE_NONE, 4'd0, 8'd3, METH_GET,  1'b1, 1'b1, ERR_TOKEN}},
    '{26, '{8'h0A, ROLE_NONE, 4'd0, 8'd0, METH_NONE, 1'b1, 1'b0, ERR_METHOD}},
    '{27, '{8'h0A, ROLE_NONE, 4'd0, 8'd1, METH_NONE, 1'b1, 1'b1, ERR_METHOD}}
  };

  http_request_header_tokenizer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .role_o           (role_o),
    .value_index_o    (value_index_o),
    .line_index_o     (line_index_o),
    .method_code_o    (method_code_o),
    .line_end_o       (line_end_o),
    .header_done_o    (header_done_o),
    .error_code_o     (error_code_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_line_limit_i (cfg_line_limit_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 16);
  end

  function automatic void restart_request();
    st_phase   = PH_METHOD;
    st_len     = '0;
    st_match   = 4'hF;
    st_pos     = '0;
    st_vals    = '0;
    st_lines   = '0;
    st_started = 1'b0;
    st_err     = ERR_NONE;
    st_meth    = METH_NONE;
  endfunction

  // first error since the last blank line wins
  function automatic void note_error(input err_e e);
    if (st_err == ERR_NONE) st_err = e;
  endfunction

  function automatic void close_method();
    st_meth = METH_NONE;
    for (int m = 0; m < 4; m++) begin
      if (st_match[m] && st_pos == meth_words[m].len()) st_meth = meth_e'(3'(m + 1));
    end
    if (st_meth == METH_NONE) note_error(ERR_METHOD);
  endfunction

  function automatic tag_t tokenize_byte(input logic [7:0] b);
    tag_t t;
    bit   blank;
    t = '0;
    t.out_byte = b;
    t.line_index = st_lines;
    blank = 1'b0;
    if (b == CharLf) begin
      t.line_end = 1'b1;
      if (st_len == '0) begin
        t.header_done = 1'b1;
        blank = 1'b1;
      end else begin
        case (st_phase)
          PH_METHOD: begin
            if (st_started) close_method();
            note_error(ERR_TOKEN);
          end
          PH_PATH, PH_QUERY, PH_NAME: begin
            note_error(ERR_TOKEN);
          end
          PH_VERSION: begin
            if (!st_started) note_error(ERR_TOKEN);
          end
          default: begin
          end
        endcase
        if (st_lines != 8'hFF) st_lines++;
        st_phase = PH_NAME;
        st_len = '0;
        st_vals = '0;
        st_started = 1'b0;
      end
    end else if (b != CharCr) begin
      if (st_len >= st_limit) note_error(ERR_TOO_LONG);
      if (st_len != LenMax) st_len++;
      case (st_phase)
        PH_METHOD: begin
          if (b == CharSpace) begin
            if (st_started) begin
              close_method();
              st_phase = PH_PATH;
              st_started = 1'b0;
            end
          end else begin
            t.role = ROLE_METHOD;
            st_started = 1'b1;
            for (int m = 0; m < 4; m++) begin
              if (st_pos >= meth_words[m].len() || meth_words[m][st_pos] != b) begin
                st_match[m] = 1'b0;
              end
            end
            if (st_pos != 3'd7) st_pos++;
          end
        end
        PH_PATH: begin
          if (b == CharSpace) begin
            if (st_started) begin
              st_phase = PH_VERSION;
              st_started = 1'b0;
            end
          end else if (b == CharQmark) begin
            st_phase = PH_QUERY;
            st_started = 1'b1;
          end else begin
            t.role = ROLE_PATH;
            st_started = 1'b1;
          end
        end
        PH_QUERY: begin
          if (b == CharSpace) begin
            st_phase = PH_VERSION;
            st_started = 1'b0;
          end else begin
            t.role = ROLE_QUERY;
          end
        end
        PH_VERSION: begin
          if (b == CharSpace) begin
            if (st_started) st_phase = PH_TAIL;
          end else begin
            t.role = ROLE_VERSION;
            st_started = 1'b1;
          end
        end
        PH_NAME: begin
          if (b == CharColon) begin
            if (!st_started) note_error(ERR_TOKEN);
            st_phase = PH_VALUE;
            st_started = 1'b0;
            st_vals = '0;
          end else if (b != CharSpace || st_started) begin
            t.role = ROLE_NAME;
            st_started = 1'b1;
          end
        end
        PH_VALUE: begin
          if (b == CharComma) begin
            if (st_vals != 4'd15) st_vals++;
            st_started = 1'b0;
          end else if (b != CharSpace || st_started) begin
            t.role = ROLE_VALUE;
            st_started = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (t.role == ROLE_VALUE) t.value_index = st_vals;
    end
    t.error_code = st_err;
    t.method_code = st_meth;
    if (st_err != ERR_NONE) begin
      t.role = ROLE_NONE;
      t.value_index = '0;
    end
    if (blank) restart_request();
    return t;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    tag_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        results_checked++;
        if (pending_tags.size() == 0) begin
          $error("result with no byte waiting: out_byte %0d", out_byte_o);
          fails++;
        end else begin
          want = pending_tags.pop_front();
          compare_field("out_byte", want.out_byte, out_byte_o);
          compare_field("role", want.role, role_o);
          compare_field("value_index", want.value_index, value_index_o);
          compare_field("line_index", want.line_index, line_index_o);
          compare_field("method_code", want.method_code, method_code_o);
          compare_field("line_end", want.line_end, line_end_o);
          compare_field("header_done", want.header_done, header_done_o);
          compare_field("error_code", want.error_code, error_code_o);
          if (want.header_done) requests_ended++;
          if (want.error_code != ERR_NONE) flagged_bytes++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        want = tokenize_byte(in_byte_i);
        pending_tags.push_back(use_typed ? typed_tag : want);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        st_limit = cfg_line_limit_i;
      end
      if (moved) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input tag_t want);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    use_typed <= typed;
    typed_tag <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    while (pending_tags.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] lim);
    in_valid_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_line_limit_i <= lim;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0: return 8'($urandom_range(0, 255));
      1: return 8'h2F;
      2: return 8'($urandom_range(8'h30, 8'h39));
      3: return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endfunction

  function automatic void put_chars(input int unsigned n);
    repeat (n) stream_q.push_back(pick_char());
  endfunction

  function automatic void put_spaces(input int unsigned n);
    repeat (n) stream_q.push_back(CharSpace);
  endfunction

  function automatic void put_eol();
    if ($urandom_range(0, 3) != 0) stream_q.push_back(CharCr);
    stream_q.push_back(CharLf);
  endfunction

  // mostly well-formed requests with random tokens, some cut short, mangled or prefixed with noise
  function automatic void compose_request();
    string       verb;
    int unsigned cut;
    int unsigned vals;
    verb = meth_words[$urandom_range(0, 3)];
    cut = $urandom_range(0, 15);
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom_range(0, 255)));
    end
    put_spaces($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 19))
      0: put_chars($urandom_range(1, 9));
      1: put_text(verb.substr(0, $urandom_range(0, verb.len() - 2)));
      2: begin
        put_text(verb);
        put_chars($urandom_range(1, 3));
      end
      default: put_text(verb);
    endcase
    if (cut != 0) begin
      put_spaces(1 + ($urandom_range(0, 4) == 0));
      if ($urandom_range(0, 7) != 0) stream_q.push_back(8'h2F);
      put_chars($urandom_range(0, 8));
      if ($urandom_range(0, 2) == 0) begin
        stream_q.push_back(CharQmark);
        put_chars($urandom_range(0, 6));
      end
      if (cut != 1) begin
        put_spaces(1 + ($urandom_range(0, 4) == 0));
        if ($urandom_range(0, 5) == 0) begin
          put_chars($urandom_range(1, 4));
        end else begin
          put_text("HTTP/1.1");
        end
        if ($urandom_range(0, 5) == 0) begin
          put_spaces(1);
          put_chars($urandom_range(1, 3));
        end
      end
    end
    put_eol();
    repeat ($urandom_range(0, 4)) begin
      put_spaces($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 11) != 0) put_chars($urandom_range(1, 8));
      if ($urandom_range(0, 11) != 0) begin
        stream_q.push_back(CharColon);
        vals = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 3);
        for (int v = 0; v <= vals; v++) begin
          put_spaces($urandom_range(0, 1));
          put_chars($urandom_range(0, 6));
          if (v < vals) stream_q.push_back(CharComma);
        end
      end
      put_eol();
    end
    if ($urandom_range(0, 7) == 0) begin
      stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
    put_eol();
  endfunction

  task automatic flush_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front(), 1'b0, '0);
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      compose_request();
      flush_stream();
    end
  endtask

  initial begin
    int unsigned k;
    restart_request();
    st_limit = LineLimitReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    k = 0;
    foreach (opening_bytes[i]) begin
      if (k < $size(known_rows) && known_rows[k].at == i) begin
        send_byte(opening_bytes[i], 1'b1, known_rows[k].want);
        k++;
      end else begin
        send_byte(opening_bytes[i], 1'b0, '0);
      end
    end
    run_random(160);

    write_limit(10'd1);
    run_random(120);

    write_limit(LenMax);
    run_random(120);

    calm = 1'b1;
    write_limit(10'($urandom_range(2, 64)));
    run_random(200);
    calm = 1'b0;

    write_limit(10'($urandom_range(2, 64)));
    run_random(120);

    // enough header lines to saturate the line number
    write_limit(LineLimitReset);
    put_text("POST / HTTP/1.1");
    put_eol();
    repeat (258) begin
      stream_q.push_back(8'h68);
      stream_q.push_back(CharLf);
    end
    put_eol();
    flush_stream();
    run_random(100);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("%0d bytes sent under %0d line limit writes, %0d results checked",
             bytes_sent, limit_writes, results_checked);
    $display("%0d requests closed by a blank line, %0d bytes reported under an error",
             requests_ended, flagged_bytes);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
